>>> hw/rtl/lwe_dr_pkg.sv
// Shared types and constants for the LWE decryption-with-rounding core.
package lwe_dr_pkg;

    localparam int FIELD_BITS   = 64;
    localparam int PLAIN_BITS   = 17;
    localparam int MSG_BITS     = 16;
    localparam int SCALE_STEPS  = PLAIN_BITS + 1;
    localparam int CFG_IDX_BITS = 1;

    localparam logic [PLAIN_BITS-1:0] PLAIN_MAX   = 17'd65536;
    localparam logic [PLAIN_BITS-1:0] PLAIN_RESET = 17'd16;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CIPHER_MODULUS = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PLAIN_MODULUS  = 1'b1;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_REDUCE = 9'b000000010,
        ST_SETUP  = 9'b000000100,
        ST_MUL    = 9'b000001000,
        ST_ACC    = 9'b000010000,
        ST_NEG    = 9'b000100000,
        ST_PHASE  = 9'b001000000,
        ST_ROUND  = 9'b010000000,
        ST_SCALE  = 9'b100000000
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
    } red_ctrl_t;

endpackage

>>> hw/rtl/lwe_decrypt_round_core.sv
// LWE decryption core: streams (a_i, s_i) pairs, keeps sum(a_i*s_i) mod q and, on the item
// flagged last, returns floor(p*((b - acc + floor(q/2p)) mod q)/q). A stored q of zero means
// q = 2^MOD_BITS; p of zero acts as 1 and p above 65536 as 65536. Items are taken one at a
// time: the next request is held off until the core is back in idle, and a last item also
// waits for the result register to drain. Operand reduction and the interleaved modular
// multiply are bit-serial, each one bit per cycle, and scaling by p is bit-serial too.
// Configuration is taken whenever the core is idle and no request is offered.
module lwe_decrypt_round_core #(
    parameter int MOD_BITS = 64
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic [lwe_dr_pkg::FIELD_BITS-1:0]    mask_coeff,
    input  logic [lwe_dr_pkg::FIELD_BITS-1:0]    secret_coeff,
    input  logic [lwe_dr_pkg::FIELD_BITS-1:0]    body,
    input  logic                                 last,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic [lwe_dr_pkg::MSG_BITS-1:0]      message,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lwe_dr_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [lwe_dr_pkg::FIELD_BITS-1:0]    cfg_data
);
    import lwe_dr_pkg::*;

    localparam int W     = MOD_BITS;
    localparam int CNT_W = $clog2((MOD_BITS > SCALE_STEPS) ? MOD_BITS : SCALE_STEPS);
    localparam int HD_W  = $clog2(MOD_BITS + 2);
    localparam int DIV_W = PLAIN_BITS + 1;
    localparam logic [MOD_BITS-1:0] QMOD_RESET = MOD_BITS'(64'd1024);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [W-1:0]      qmod_reg;
    logic [PLAIN_BITS-1:0] pmod_reg;
    logic [W-1:0]      ip_reg, ip_next;
    logic              out_valid_reg, out_valid_next;
    logic [HD_W-1:0]   hd_cnt_reg, hd_cnt_next;

    logic              last_reg;
    logic [W-1:0]      body_reg;
    logic [W-1:0]      ipr_reg;
    logic [W-1:0]      acc_reg;
    logic [W:0]        opa_reg;
    logic [W-1:0]      mb_reg;
    logic [DIV_W-1:0]  ps_reg;
    logic [DIV_W-1:0]  quot_reg;
    logic [W:0]        hd_sh_reg;
    logic [DIV_W-1:0]  hd_rem_reg;
    logic [MSG_BITS-1:0] msg_reg;

    logic              accept;
    logic              emit_go;
    logic [W:0]        qe;
    logic [PLAIN_BITS-1:0] p_eff;
    logic [DIV_W-1:0]  divisor;

    logic              st_dbl;
    logic              st_add;
    logic [W:0]        st_y;
    logic [W+1:0]      st_t;
    logic [W+1:0]      st_q1;
    logic [W+1:0]      st_q2;
    logic [W-1:0]      st_r;
    logic [1:0]        st_c;

    logic [DIV_W:0]    hd_t;
    logic              hd_ge;

    red_ctrl_t         ra_ctrl, rb_ctrl, rc_ctrl;
    logic [W-1:0]      ra_rem, rb_rem, rc_rem;
    logic [W-1:0]      rc_din;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE);
    // a write never lands on the edge that takes a request
    assign cfg_ready = (state_reg == ST_IDLE) && !in_valid;
    assign out_valid = out_valid_reg;
    assign message   = msg_reg;
    assign emit_go   = !out_valid_reg || !out_stall;

    // zero modulus stands for 2^W
    assign qe = {(qmod_reg == '0), qmod_reg};

    always_comb
    begin
        if (pmod_reg == '0)
            p_eff = PLAIN_BITS'(1);
        else if (pmod_reg > PLAIN_MAX)
            p_eff = PLAIN_MAX;
        else
            p_eff = pmod_reg;
    end

    assign divisor = {p_eff, 1'b0};

    // operand reduction units
    assign ra_ctrl = '{load: accept, step: (state_reg == ST_REDUCE)};
    assign rb_ctrl = '{load: accept, step: (state_reg == ST_REDUCE)};
    assign rc_ctrl = '{load: accept || (state_reg == ST_SETUP),
                       step: (state_reg == ST_REDUCE) || (state_reg == ST_MUL)};
    assign rc_din  = (state_reg == ST_SETUP) ? body_reg : ip_reg;

    lwe_dr_reduce #(.W(W)) u_red_a (
        .clk  (clk),
        .ctrl (ra_ctrl),
        .din  (mask_coeff[W-1:0]),
        .qe   (qe),
        .rem  (ra_rem)
    );

    lwe_dr_reduce #(.W(W)) u_red_b (
        .clk  (clk),
        .ctrl (rb_ctrl),
        .din  (secret_coeff[W-1:0]),
        .qe   (qe),
        .rem  (rb_rem)
    );

    // inner product first, then the body during the multiply
    lwe_dr_reduce #(.W(W)) u_red_c (
        .clk  (clk),
        .ctrl (rc_ctrl),
        .din  (rc_din),
        .qe   (qe),
        .rem  (rc_rem)
    );

    // shared modular step: (dbl ? 2x : x) + y, reduced from below 3q; st_c counts the wraps
    always_comb
    begin
        st_dbl = 1'b0;
        st_add = 1'b0;
        case (state_reg)
            ST_MUL:
            begin
                st_dbl = 1'b1;
                st_add = mb_reg[W-1];
            end
            ST_ACC, ST_PHASE, ST_ROUND:
            begin
                st_add = 1'b1;
            end
            ST_SCALE:
            begin
                st_dbl = 1'b1;
                st_add = ps_reg[DIV_W-1];
            end
            default:
            begin
                st_dbl = 1'b0;
                st_add = 1'b0;
            end
        endcase
    end

    assign st_y  = (state_reg == ST_ACC) ? {1'b0, ipr_reg} : opa_reg;
    assign st_t  = (st_dbl ? {1'b0, acc_reg, 1'b0} : {2'b00, acc_reg})
                 + (st_add ? {1'b0, st_y} : '0);
    assign st_q1 = {1'b0, qe};
    assign st_q2 = {qe, 1'b0};

    always_comb
    begin
        if (st_t >= st_q2)
        begin
            st_r = W'(st_t - st_q2);
            st_c = 2'd2;
        end
        else if (st_t >= st_q1)
        begin
            st_r = W'(st_t - st_q1);
            st_c = 2'd1;
        end
        else
        begin
            st_r = st_t[W-1:0];
            st_c = 2'd0;
        end
    end

    // restoring divider for floor(q / 2p), started with each request
    assign hd_t  = {hd_rem_reg, hd_sh_reg[W]};
    assign hd_ge = (hd_t >= {1'b0, divisor});

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        ip_next        = ip_reg;
        out_valid_next = out_valid_reg && out_stall;
        hd_cnt_next    = (hd_cnt_reg != '0) ? hd_cnt_reg - HD_W'(1) : hd_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next  = ST_REDUCE;
                    cnt_next    = CNT_W'(MOD_BITS - 1);
                    hd_cnt_next = HD_W'(MOD_BITS + 1);
                end
            end
            ST_REDUCE:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                    state_next = ST_SETUP;
            end
            ST_SETUP:
            begin
                state_next = ST_MUL;
                cnt_next   = CNT_W'(MOD_BITS - 1);
            end
            ST_MUL:
            begin
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                    state_next = ST_ACC;
            end
            ST_ACC:
            begin
                if (last_reg)
                begin
                    ip_next    = '0;
                    state_next = ST_NEG;
                end
                else
                begin
                    ip_next    = st_r;
                    state_next = ST_IDLE;
                end
            end
            ST_NEG:
            begin
                state_next = ST_PHASE;
            end
            ST_PHASE:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                state_next = ST_SCALE;
                cnt_next   = CNT_W'(SCALE_STEPS - 1);
            end
            ST_SCALE:
            begin
                if (cnt_reg == '0)
                begin
                    if (emit_go)
                    begin
                        out_valid_next = 1'b1;
                        state_next     = ST_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            ip_reg        <= '0;
            out_valid_reg <= 1'b0;
            hd_cnt_reg    <= '0;
            qmod_reg      <= QMOD_RESET;
            pmod_reg      <= PLAIN_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ip_reg        <= ip_next;
            out_valid_reg <= out_valid_next;
            hd_cnt_reg    <= hd_cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_CIPHER_MODULUS: qmod_reg <= cfg_data[W-1:0];
                    CFG_PLAIN_MODULUS:  pmod_reg <= cfg_data[PLAIN_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // divider datapath
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hd_sh_reg  <= qe;
            hd_rem_reg <= '0;
        end
        else if (hd_cnt_reg != '0)
        begin
            hd_sh_reg  <= {hd_sh_reg[W-1:0], hd_ge};
            hd_rem_reg <= hd_ge ? DIV_W'(hd_t - {1'b0, divisor}) : hd_t[DIV_W-1:0];
        end
    end

    // main datapath; the final scale step is held until the result register is free
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            body_reg <= body[W-1:0];
            last_reg <= last;
        end
        case (state_reg)
            ST_SETUP:
            begin
                ipr_reg <= rc_rem;
                mb_reg  <= rb_rem;
                opa_reg <= {1'b0, ra_rem};
                acc_reg <= '0;
            end
            ST_MUL:
            begin
                acc_reg <= st_r;
                mb_reg  <= mb_reg << 1;
            end
            ST_ACC:
            begin
                acc_reg <= st_r;
            end
            ST_NEG:
            begin
                // q - acc lies in (0, q]; body + (q - acc) wraps to the phase
                opa_reg <= qe - {1'b0, acc_reg};
                acc_reg <= rc_rem;
            end
            ST_PHASE:
            begin
                acc_reg <= st_r;
                opa_reg <= {1'b0, hd_sh_reg[W-1:0]};
            end
            ST_ROUND:
            begin
                opa_reg  <= {1'b0, st_r};
                acc_reg  <= '0;
                ps_reg   <= {1'b0, p_eff};
                quot_reg <= '0;
            end
            ST_SCALE:
            begin
                if (cnt_reg != '0 || emit_go)
                begin
                    acc_reg  <= st_r;
                    ps_reg   <= ps_reg << 1;
                    quot_reg <= {quot_reg[DIV_W-2:0], 1'b0} + DIV_W'(st_c);
                end
                if (cnt_reg == '0 && emit_go)
                    msg_reg <= MSG_BITS'({quot_reg[DIV_W-2:0], 1'b0} + DIV_W'(st_c));
            end
            default: ;
        endcase
    end

`ifndef SYNTH
    a_out_from_scale: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_SCALE))
        else $error("result raised outside the scaling step");

    a_ip_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC) && !last_reg |=> ({1'b0, ip_reg} < qe))
        else $error("inner product not reduced mod q");

    a_msg_range: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ({1'b0, msg_reg} < p_eff))
        else $error("message not below plain modulus");

    a_half_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PHASE) |-> (hd_cnt_reg == '0))
        else $error("rounding offset not ready at phase step");
`endif

endmodule

>>> hw/rtl/lwe_dr_reduce.sv
// Bit-serial reduction of one operand modulo a runtime modulus, MSB first.
module lwe_dr_reduce #(
    parameter int W = 64
) (
    input  logic                  clk,
    input  lwe_dr_pkg::red_ctrl_t ctrl,
    input  logic [W-1:0]          din,
    input  logic [W:0]            qe,
    output logic [W-1:0]          rem
);
    import lwe_dr_pkg::*;

    logic [W-1:0] sh_reg;
    logic [W-1:0] rem_reg;
    logic [W:0]   trial;
    logic         ge;

    // rem < q, so 2*rem + bit < 2q and one subtract is enough
    assign trial = {rem_reg, sh_reg[W-1]};
    assign ge    = (trial >= qe);
    assign rem   = rem_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            sh_reg  <= din;
            rem_reg <= '0;
        end
        else if (ctrl.step)
        begin
            sh_reg  <= sh_reg << 1;
            rem_reg <= ge ? W'(trial - qe) : trial[W-1:0];
        end
    end

endmodule
